@@ sv/muxed_seven_segment_display_assert.svh @@
// Assertion macros used by the checker file
`ifndef MUXED_SEVEN_SEGMENT_DISPLAY_ASSERT_SVH
`define MUXED_SEVEN_SEGMENT_DISPLAY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define MSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
		else $error(msg);

`endif

@@ sv/mss_pkg.sv @@
// Shared types, constants and the digit pattern table for the display controller
package mss_pkg;

	// default geometry
	localparam int MSS_DIGITS = 8;
	localparam int MSS_LINES  = 2;

	localparam int SEG_WIDTH = 8;

	// reciprocal of ten, used with a shift of 35
	localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

	localparam logic [SEG_WIDTH-1:0] SEG_BLANK = 8'h00;
	localparam logic [SEG_WIDTH-1:0] SEG_POINT = 8'h01;

	// command codes
	localparam logic [1:0] MODE_NUMBER = 2'd0;
	localparam logic [1:0] MODE_RAW    = 2'd1;
	localparam logic [1:0] MODE_SCAN   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_COMMON_ANODE = 2'd0;
	localparam logic [1:0] CFG_BLINK_DIGIT  = 2'd1;
	localparam logic [1:0] CFG_BLINK_LINE   = 2'd2;
	localparam logic [1:0] CFG_BLINK_PERIOD = 2'd3;

	typedef struct packed {
		logic       common_anode;
		logic [2:0] blink_digit;
		logic       blink_line;
		logic [7:0] blink_period;
	} cfg_t;

	// scan stage towards the output
	typedef struct packed {
		logic       strobe;
		logic [3:0] sel;
		logic       blank;
	} scan_out_t;

	// decimal digit to segments a..g in bits 7..1
	function automatic logic [SEG_WIDTH-1:0] digit_pattern(input logic [3:0] d);
		logic [SEG_WIDTH-1:0] p;
		unique case (d)
			4'd0:    p = 8'b1111_1100;
			4'd1:    p = 8'b0110_0000;
			4'd2:    p = 8'b1101_1010;
			4'd3:    p = 8'b1111_0010;
			4'd4:    p = 8'b0110_0110;
			4'd5:    p = 8'b1011_0110;
			4'd6:    p = 8'b1011_1110;
			4'd7:    p = 8'b1110_0000;
			4'd8:    p = 8'b1111_1110;
			4'd9:    p = 8'b1111_0110;
			default: p = SEG_BLANK;
		endcase
		return p;
	endfunction

endpackage

@@ sv/muxed_seven_segment_display.sv @@
// Top level of the multiplexed seven-segment display controller
//
// Commands enter on start while busy is low; mode selects the command.
//   Number write (mode 0): converts number to decimal, one digit a cycle,
//     into one line of the segment store; busy is high while it runs.
//   Raw write (mode 1): stores segments_in at line/position.
//   Scan tick (mode 2): reads the next digit of the store. The word
//     appears on digit_select/segments_out with strobe in the next cycle.
//     Ticks may follow every cycle while busy is low. Mode 3 does nothing.
// A number write keeps busy high while the conversion sequencer does one
// divide by ten a cycle; raw writes and scan ticks leave the block free.
// Configuration (common anode, blink digit/line/period) is written on
// cfg_we/cfg_index/cfg_data; the user must do so only while idle, as
// the block does not enforce it. Reset clears the scan position, blink
// timer and configuration, and the per-entry valid flags, so the whole
// store reads blank at once with no clearing pass. Results are held for
// exactly one cycle: the receiver must take them when strobe is high and
// cannot stall the block.
module muxed_seven_segment_display #(
	parameter int DIGITS = mss_pkg::MSS_DIGITS,
	parameter int LINES = mss_pkg::MSS_LINES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] mode,
	input  logic [31:0] number,
	input  logic       line,
	input  logic [2:0] decimal_place,
	input  logic       blank_leading,
	input  logic [2:0] position,
	input  logic [7:0] segments_in,
	output logic       strobe,
	output logic [3:0] digit_select,
	output logic [7:0] segments_out,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	import mss_pkg::*;

	localparam int DEPTH = LINES * DIGITS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic accept;
	logic line_ok;
	logic do_number;
	logic do_raw;
	logic do_scan;

	cfg_t cfg_q;

	logic                 conv_busy;
	logic                 conv_we;
	logic [AW-1:0]        conv_addr;
	logic [SEG_WIDTH-1:0] conv_data;
	logic [AW-1:0]        row_base;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [SEG_WIDTH-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [SEG_WIDTH-1:0] ram_rdata;

	logic [DEPTH-1:0] valid_q;
	logic             valid_s1;
	scan_out_t        scan_s1;
	logic [SEG_WIDTH-1:0] pat;

	assign accept  = start && !conv_busy;
	assign line_ok = (32'(line) < LINES);

	// command decode
	always_comb begin
		do_number = 1'b0;
		do_raw    = 1'b0;
		do_scan   = 1'b0;
		unique case (mode)
			MODE_NUMBER: do_number = accept && line_ok;
			MODE_RAW:    do_raw = accept && line_ok && (32'(position) < DIGITS);
			MODE_SCAN:   do_scan = accept;
			default:     ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COMMON_ANODE: cfg_q.common_anode <= cfg_data[0];
				CFG_BLINK_DIGIT:  cfg_q.blink_digit <= cfg_data[2:0];
				CFG_BLINK_LINE:   cfg_q.blink_line <= cfg_data[0];
				CFG_BLINK_PERIOD: cfg_q.blink_period <= cfg_data;
			endcase
		end
	end

	assign row_base = AW'(32'(line) * DIGITS);

	mss_conv #(
		.DIGITS (DIGITS),
		.AW     (AW)
	) u_conv (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (do_number),
		.number        (number),
		.row_base      (row_base),
		.decimal_place (decimal_place),
		.blank_leading (blank_leading),
		.busy          (conv_busy),
		.wr_en         (conv_we),
		.wr_addr       (conv_addr),
		.wr_data       (conv_data)
	);

	mss_scan #(
		.DIGITS (DIGITS),
		.LINES  (LINES),
		.AW     (AW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (do_scan),
		.cfg     (cfg_q),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.scan_s1 (scan_s1)
	);

	// store write port: conversion owns it while busy
	assign ram_we    = conv_we || do_raw;
	assign ram_waddr = conv_we ? conv_addr : AW'(32'(line) * DIGITS + 32'(position));
	assign ram_wdata = conv_we ? conv_data : segments_in;

	mss_ram #(
		.WIDTH (SEG_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// valid flags: an entry never written reads blank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < DEPTH; i++) begin
				if (ram_we && (ram_waddr == AW'(i))) begin
					valid_q[i] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			valid_s1 <= valid_q[ram_raddr];
		end
	end

	// output word
	always_comb begin
		pat = (valid_s1 && !scan_s1.blank) ? ram_rdata : SEG_BLANK;
		if (cfg_q.common_anode) begin
			pat = ~pat;
		end
	end

	assign busy         = conv_busy;
	assign strobe       = scan_s1.strobe;
	assign digit_select = scan_s1.sel;
	assign segments_out = pat;

endmodule

@@ sv/mss_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module mss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/mss_conv.sv @@
// Number conversion sequencer: one decimal digit per cycle into the segment store
module mss_conv #(
	parameter int DIGITS = 8,
	parameter int AW = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [31:0]                   number,
	input  logic [AW-1:0]                 row_base,
	input  logic [2:0]                    decimal_place,
	input  logic                          blank_leading,
	output logic                          busy,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [mss_pkg::SEG_WIDTH-1:0] wr_data
);

	import mss_pkg::*;

	localparam int DIG_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic             busy_q;
	logic [DIG_W-1:0] cnt_q;
	logic [31:0]      value_q;
	logic [AW-1:0]    base_q;
	logic [2:0]       dp_q;
	logic             blank_q;

	logic [63:0]          prod;
	logic [28:0]          quot;
	logic [3:0]           rem;
	logic                 show;
	logic                 last;
	logic [SEG_WIDTH-1:0] pat;

	// divide by ten through the reciprocal; remainder needs only four bits
	assign prod = {32'b0, value_q} * {32'b0, RECIP_10};
	assign quot = prod[63:35];
	assign rem  = value_q[3:0] - ({quot[0], 3'b000} + {quot[2:0], 1'b0});

	assign show = (value_q != 32'd0) || (32'(cnt_q) <= 32'(dp_q));
	assign last = (32'(cnt_q) == DIGITS - 1);

	// pattern for the current position, point ORed in at a nonzero decimal place
	always_comb begin
		if (show) begin
			pat = digit_pattern(rem);
		end else if (blank_q) begin
			pat = SEG_BLANK;
		end else begin
			pat = digit_pattern(4'd0);
		end
		if ((dp_q != 3'd0) && (32'(cnt_q) == 32'(dp_q))) begin
			pat = pat | SEG_POINT;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIG_W'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// working value and command fields
	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= number;
			base_q  <= row_base;
			dp_q    <= decimal_place;
			blank_q <= blank_leading;
		end else if (busy_q) begin
			value_q <= 32'(quot);
		end
	end

	assign busy    = busy_q;
	assign wr_en   = busy_q;
	assign wr_addr = base_q + AW'(cnt_q);
	assign wr_data = pat;

endmodule

@@ sv/mss_scan.sv @@
// Scan position and blink timer; issues the store read for each scan tick
module mss_scan #(
	parameter int DIGITS = 8,
	parameter int LINES = 2,
	parameter int AW = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick,
	input  mss_pkg::cfg_t      cfg,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	output mss_pkg::scan_out_t scan_s1
);

	import mss_pkg::*;

	localparam int DIG_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;

	logic [DIG_W-1:0]  digit_q;
	logic [LINE_W-1:0] line_q;
	logic [7:0]        count_q;
	logic              phase_q;

	logic [7:0] count_inc;
	logic [7:0] count_n;
	logic       phase_n;
	logic       blank;

	logic       strobe_s1;
	logic [3:0] sel_s1;
	logic       blank_s1;

	// blink timer as seen by this tick
	assign count_inc = count_q + 8'd1;
	always_comb begin
		count_n = count_q;
		phase_n = phase_q;
		if (cfg.blink_period != 8'd0) begin
			if (count_inc == cfg.blink_period) begin
				phase_n = ~phase_q;
				count_n = 8'd0;
			end else begin
				count_n = count_inc;
			end
		end else begin
			phase_n = 1'b0;
		end
	end

	assign blank = phase_n && (32'(digit_q) == 32'(cfg.blink_digit))
	               && (32'(line_q) == 32'(cfg.blink_line));

	assign rd_en   = tick;
	assign rd_addr = AW'(32'(line_q) * DIGITS + 32'(digit_q));

	// scan position and blink state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
			line_q  <= '0;
			count_q <= 8'd0;
			phase_q <= 1'b0;
		end else if (tick) begin
			count_q <= count_n;
			phase_q <= phase_n;
			if (32'(digit_q) == DIGITS - 1) begin
				digit_q <= '0;
				if (32'(line_q) == LINES - 1) begin
					line_q <= '0;
				end else begin
					line_q <= line_q + LINE_W'(1);
				end
			end else begin
				digit_q <= digit_q + DIG_W'(1);
			end
		end
	end

	// result strobe, aligned with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= tick;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			sel_s1   <= 4'(32'(line_q) * DIGITS + 32'(digit_q));
			blank_s1 <= blank;
		end
	end

	assign scan_s1 = '{strobe: strobe_s1, sel: sel_s1, blank: blank_s1};

endmodule

@@ sv/mss_checker.sv @@
// Port-level checker for the display controller, bound to the top level
`include "muxed_seven_segment_display_assert.svh"

module mss_checker #(
	parameter int DIGITS = 8,
	parameter int LINES = 2
) (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] mode,
	input logic       line,
	input logic       strobe
);

	import mss_pkg::*;

	// a scan tick gives its word in the next cycle, and only then
	`MSS_ASSERT_NEXT(a_scan_word, clk, arst_n, start && !busy && mode == MODE_SCAN, strobe, "scan tick without word")
	`MSS_ASSERT_IMPL(a_word_cause, clk, arst_n, strobe, $past(start && !busy && mode == MODE_SCAN), "word without scan tick")

	// a number write to a valid line makes the block busy; the conversion length is checked
	`MSS_ASSERT_NEXT(a_number_busy, clk, arst_n, start && !busy && mode == MODE_NUMBER && (32'(line) < LINES), busy, "number write did not start")
	`MSS_ASSERT_IMPL(a_busy_len, clk, arst_n, $rose(busy), ##DIGITS !busy, "conversion length wrong")

endmodule

bind muxed_seven_segment_display mss_checker #(
	.DIGITS (DIGITS),
	.LINES  (LINES)
) u_mss_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.mode   (mode),
	.line   (line),
	.strobe (strobe)
);
